FILE: rtl/core/pcs_pkg.sv
// Shared types, constants and the configuration-space template of the
// PCI configuration space emulator. No dependencies.
package pcs_pkg;

   localparam int LANES     = 4;
   localparam int TPL_WORDS = 64;

   typedef enum logic [1:0] {
      FUNC_READ    = 2'd0,
      FUNC_WRITE   = 2'd1,
      FUNC_REBUILD = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_DEV  = 2'd1,
      ST_BAD_REG = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_DEVICE_ID = 3'd0,
      CSR_REVISION  = 3'd1,
      CSR_BAR0_BASE = 3'd2,
      CSR_BAR0_SIZE = 3'd3,
      CSR_OWN_BUS   = 3'd4,
      CSR_OWN_SLOT  = 3'd5,
      CSR_INTX_LINE = 3'd6
   } csr_index_type;

   // Values the rebuild patches into the template, captured at rebuild.
   typedef struct packed {
      logic [15:0] device_id;
      logic [7:0]  revision;
      logic [27:0] bar0_base_hi;
      logic [7:0]  intx_line;
   } patch_type;

   localparam logic [2:0]  SIZE_BYTE = 3'd1;
   localparam logic [2:0]  SIZE_HALF = 3'd2;
   localparam logic [2:0]  SIZE_WORD = 3'd4;

   localparam logic [15:0] VENDOR_ID   = 16'h14e4;
   localparam logic [15:0] CLASS_CODE  = 16'h0280;
   localparam logic [3:0]  BAR_TYPE    = 4'h4;
   localparam logic [7:0]  INTX_PIN_A  = 8'h01;
   localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;

   localparam logic [11:0] BAR_FIRST_OFF = 12'h010;
   localparam logic [11:0] BAR_LAST_OFF  = 12'h024;
   localparam logic [11:0] ROM_OFF       = 12'h030;
   localparam logic [9:0]  BAR0_WORD     = 10'd4;

   localparam logic [10:0] IDX_ID_WORD    = 11'd0;
   localparam logic [10:0] IDX_CLASS_WORD = 11'd2;
   localparam logic [10:0] IDX_BAR0_WORD  = 11'd4;
   localparam logic [10:0] IDX_SUBSYS     = 11'd11;
   localparam logic [10:0] IDX_INTR_WORD  = 11'd15;

   localparam logic [31:0] RST_BAR0_SIZE = 32'h0800_0000;
   localparam logic [7:0]  RST_OWN_BUS   = 8'd1;

   function automatic logic [31:0] tpl_word(input logic [5:0] idx);
      logic [31:0] w;
      case (idx)
         6'd1:    w = 32'h0010_0000;
         6'd6:    w = 32'h0000_0004;
         6'd8:    w = 32'h0000_000c;
         6'd13:   w = 32'h0000_0048;
         6'd18:   w = 32'h0603_5801;
         6'd19:   w = 32'h0000_4108;
         6'd22:   w = 32'h008b_6805;
         6'd26:   w = 32'h0000_a009;
         6'd28:   w = 32'h2810_0000;
         6'd32:   w = 32'h2800_0000;
         6'd34:   w = 32'h0000_0080;
         6'd37:   w = 32'h0000_0100;
         6'd40:   w = 32'h003f_ac11;
         6'd41:   w = 32'h0000_8000;
         6'd42:   w = 32'h0000_8800;
         6'd43:   w = 32'h0002_0010;
         6'd44:   w = 32'h0000_8f82;
         6'd45:   w = 32'h0010_2c10;
         6'd46:   w = 32'h0046_dc22;
         6'd47:   w = 32'h1022_0000;
         6'd52:   w = 32'h0008_081f;
         6'd54:   w = 32'h0000_0006;
         6'd55:   w = 32'h0000_0002;
         default: w = 32'h0000_0000;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/pcs_byte_bank.sv
// One byte lane of the configuration space: a simple dual-port memory
// with a registered read port. No dependencies.
module pcs_byte_bank #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/pcs_store.sv
// Configuration-space storage: four byte banks plus the template fill sweep
// run after reset and on rebuild. Depends on pcs_pkg and pcs_byte_bank.
module pcs_store #(
   parameter int CFG_WORDS = 64,
   localparam int AW = $clog2(CFG_WORDS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pcs_pkg::patch_type  patch,
   input  logic [3:0]          acc_we,
   input  logic [AW-1:0]       acc_addr [4],
   input  logic [31:0]         acc_wdata,
   input  logic                rd_en,
   output logic [31:0]         rd_data,
   output logic                busy
);
   import pcs_pkg::*;

   logic                busy_ff, busy_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   patch_type           snap_ff, snap_in;
   logic [10:0]         cnt_wide;
   logic [31:0]         fill;
   logic [31:0]         idw;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         snap_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         snap_ff <= snap_in;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      snap_in = snap_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         snap_in = patch;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == AW'(CFG_WORDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Template word for the sweep address, with the identity words patched.
   always_comb begin
      cnt_wide = 11'(cnt_ff);
      idw      = {snap_ff.device_id, VENDOR_ID};
      fill     = (cnt_wide < 11'(TPL_WORDS)) ? tpl_word(cnt_wide[5:0]) : 32'h0;
      if (cnt_wide == IDX_ID_WORD || cnt_wide == IDX_SUBSYS) begin
         fill = idw;
      end else if (cnt_wide == IDX_CLASS_WORD) begin
         fill = {CLASS_CODE, 8'h00, snap_ff.revision};
      end else if (cnt_wide == IDX_BAR0_WORD) begin
         fill = {snap_ff.bar0_base_hi, BAR_TYPE};
      end else if (cnt_wide == IDX_INTR_WORD) begin
         fill = {16'h0000, INTX_PIN_A, snap_ff.intx_line};
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_bank
      pcs_byte_bank #(
         .DEPTH (CFG_WORDS)
      ) u_bank (
         .clock (clock),
         .we    (busy_ff | acc_we[g]),
         .waddr (busy_ff ? cnt_ff : acc_addr[g]),
         .wdata (busy_ff ? fill[8*g +: 8] : acc_wdata[8*g +: 8]),
         .re    (rd_en),
         .raddr (acc_addr[g]),
         .rdata (rd_data[8*g +: 8])
      );
   end

   assign busy = busy_ff;

   // The sweep owns the write port; the access side must stay off it.
   a_no_start_in_sweep: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("rebuild started while the fill sweep is running");

   a_no_access_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (acc_we == 4'b0000))
      else $error("access write issued during the fill sweep");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == AW'(CFG_WORDS - 1)) |=> !busy_ff)
      else $error("fill sweep did not end at the last word");

endmodule

FILE: rtl/core/pci_config_space_emulator.sv
// Top level of the PCI type-0 configuration space emulator: register port,
// access decode, two-stage request pipeline. Depends on pcs_pkg, pcs_store.
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tuser: func; tdata: access fields
//  rsp      out        rsp_tvalid/tready    tdata: read_data, status
//  csr      in         csr_wen              csr_index, csr_wdata
//
// One request enters per cycle while req_tready is high; its response is held in the
// byte-bank read register, loaded at the accepting edge, and then in the response
// register, which drives rsp_tvalid.
// Reset and every rebuild request start a fill sweep over all CFG_WORDS words
// through the byte banks' single write port; req_tready stays low during it.
// The request stage and the response register form a two-deep queue, so a
// request is still taken while a finished response waits on rsp_tready.
module pci_config_space_emulator #(
   parameter int CFG_WORDS = 64,
   localparam int AW = $clog2(CFG_WORDS)
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = func[1:0]
   // tdata = bus_num[7:0], device_slot[12:8], offset[24:13],
   //         access_size[27:25], write_data[59:28], zero[63:60]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   // response: tdata = read_data[31:0], status[33:32], zero[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   // register write port
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pcs_pkg::*;

   localparam int CFG_BYTES = CFG_WORDS * 4;

   // configuration registers
   logic [15:0] device_id_ff;
   logic [7:0]  revision_ff;
   logic [31:0] bar0_base_ff;
   logic [31:0] bar0_size_ff;
   logic [7:0]  own_bus_ff;
   logic [4:0]  own_slot_ff;
   logic [7:0]  intx_line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= '0;
         revision_ff  <= '0;
         bar0_base_ff <= '0;
         bar0_size_ff <= RST_BAR0_SIZE;
         own_bus_ff   <= RST_OWN_BUS;
         own_slot_ff  <= '0;
         intx_line_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEVICE_ID: device_id_ff <= csr_wdata[15:0];
            CSR_REVISION:  revision_ff  <= csr_wdata[7:0];
            CSR_BAR0_BASE: bar0_base_ff <= csr_wdata;
            CSR_BAR0_SIZE: bar0_size_ff <= csr_wdata;
            CSR_OWN_BUS:   own_bus_ff   <= csr_wdata[7:0];
            CSR_OWN_SLOT:  own_slot_ff  <= csr_wdata[4:0];
            CSR_INTX_LINE: intx_line_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // request fields
   func_type    req_func;
   logic [7:0]  req_bus;
   logic [4:0]  req_slot;
   logic [11:0] req_offset;
   logic [2:0]  req_size;
   logic [31:0] req_wdata;

   assign req_func   = func_type'(req_tuser[1:0]);
   assign req_bus    = req_tdata[7:0];
   assign req_slot   = req_tdata[12:8];
   assign req_offset = req_tdata[24:13];
   assign req_size   = req_tdata[27:25];
   assign req_wdata  = req_tdata[59:28];

   // pipeline control
   logic        s1_valid_ff;
   logic        rsp_valid_ff;
   logic        out_load, s1_load, req_accept;
   logic        busy;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || out_load;
   assign req_tready = s1_load && !busy;
   assign req_accept = req_tvalid && req_tready;

   // access decode, straight off the request port
   logic          dec_match, dec_in_rng, dec_size_ok, dec_ok, dec_next_ok;
   logic [AW-1:0] dec_word, dec_next;
   logic [1:0]    dec_lane;
   logic [3:0]    dec_lane_ok;
   logic [AW-1:0] acc_addr [4];
   logic [31:0]   acc_wdata;
   logic [3:0]    acc_we;
   status_type    dec_status;

   always_comb begin
      logic [1:0] k;
      logic       wrap;
      dec_match   = (req_bus == own_bus_ff) && (req_slot == own_slot_ff);
      dec_in_rng  = {1'b0, req_offset} < 13'(CFG_BYTES);
      dec_size_ok = (req_size == SIZE_BYTE) || (req_size == SIZE_HALF) ||
                    (req_size == SIZE_WORD);
      dec_ok      = ((req_func == FUNC_READ) || (req_func == FUNC_WRITE)) &&
                    dec_match && dec_in_rng && dec_size_ok;
      dec_word    = req_offset[AW+1:2];
      dec_next    = dec_word + 1'b1;
      dec_next_ok = (11'(dec_word) + 11'd1) < 11'(CFG_WORDS);
      // word accesses ignore the low offset bits
      dec_lane    = (req_size == SIZE_WORD) ? 2'd0 : req_offset[1:0];
      for (int b = 0; b < LANES; b++) begin
         k    = 2'(b) - dec_lane;
         wrap = 2'(b) < dec_lane;
         // a halfword byte past the last word is dropped
         dec_lane_ok[b]      = ({1'b0, k} < req_size) && (!wrap || dec_next_ok);
         acc_addr[b]         = (wrap && dec_next_ok) ? dec_next : dec_word;
         acc_wdata[8*b +: 8] = req_wdata[8*k +: 8];
         acc_we[b]           = req_accept && (req_func == FUNC_WRITE) && dec_ok &&
                               dec_lane_ok[b];
      end
      if ((req_func == FUNC_REBUILD) || (req_func == FUNC_NOP)) begin
         dec_status = ST_OK;
      end else if (!dec_match) begin
         dec_status = ST_NO_DEV;
      end else if (!(dec_in_rng && dec_size_ok)) begin
         dec_status = ST_BAD_REG;
      end else begin
         dec_status = ST_OK;
      end
   end

   // storage and fill sweep
   patch_type   patch;
   logic        rebuild_start;
   logic [31:0] rd_data;

   assign patch = '{device_id:    device_id_ff,
                    revision:     revision_ff,
                    bar0_base_hi: bar0_base_ff[31:4],
                    intx_line:    intx_line_ff};
   assign rebuild_start = req_accept && (req_func == FUNC_REBUILD);

   pcs_store #(
      .CFG_WORDS (CFG_WORDS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .start     (rebuild_start),
      .patch     (patch),
      .acc_we    (acc_we),
      .acc_addr  (acc_addr),
      .acc_wdata (acc_wdata),
      .rd_en     (s1_load),
      .rd_data   (rd_data),
      .busy      (busy)
   );

   // request stage: bank read data lands alongside these
   status_type  s1_status_ff;
   logic        s1_read_ff;
   logic        s1_word_ff;
   logic [1:0]  s1_lane_ff;
   logic [3:0]  s1_lane_ok_ff;
   logic [11:0] s1_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_accept) begin
         s1_status_ff  <= dec_status;
         s1_read_ff    <= dec_ok && (req_func == FUNC_READ);
         s1_word_ff    <= req_size == SIZE_WORD;
         s1_lane_ff    <= dec_lane;
         s1_lane_ok_ff <= dec_lane_ok;
         s1_off_ff     <= req_offset;
      end
   end

   // assemble the read value from the byte banks
   logic [31:0] res_raw, res_data, bar_span;

   always_comb begin
      logic [1:0] b;
      res_raw = '0;
      for (int k = 0; k < LANES; k++) begin
         b = s1_lane_ff + 2'(k);
         res_raw[8*k +: 8] = s1_lane_ok_ff[b] ? rd_data[8*b +: 8] : 8'h00;
      end
      // only BAR0 has a size; the other BARs size as zero
      bar_span = (s1_off_ff[11:2] == BAR0_WORD) ? bar0_size_ff : 32'h0;
      res_data = res_raw;
      if (s1_word_ff) begin
         if (res_raw == ALL_ONES && s1_off_ff >= BAR_FIRST_OFF &&
             s1_off_ff <= BAR_LAST_OFF) begin
            res_data = ~(bar_span - 32'd1);
         end else if (s1_off_ff == ROM_OFF) begin
            res_data = ALL_ONES;
         end
      end
      if (!s1_read_ff) begin
         res_data = '0;
      end
   end

   // response register
   logic [31:0] rsp_data_ff;
   status_type  rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && s1_valid_ff) begin
         rsp_data_ff   <= res_data;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_status_ff, rsp_data_ff};

   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ST_OK || rsp_status_ff == ST_NO_DEV ||
                        rsp_status_ff == ST_BAD_REG))
      else $error("response carries a reserved status code");

   a_error_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_data_ff == 32'h0))
      else $error("failed request returned nonzero data");

   a_rebuild_sweeps: assert property (@(posedge clock) disable iff (reset)
      rebuild_start |=> (busy && !req_tready))
      else $error("rebuild request did not start the fill sweep");

endmodule
